// ===== src/sdst_pkg.sv =====
// Shared types and constants for the switch debounce state tracker.
`default_nettype none
package sdst_pkg;

  localparam int MAX_STATES_DEF = 64;
  localparam int STATE_W        = 6;
  localparam int NS_W           = 7;
  localparam int MAP_W          = 8;
  localparam int TIME_W         = 32;
  localparam int MS_W           = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;
  localparam int NS_MIN         = 2;

  // item kinds
  typedef enum logic [1:0] {
    MODE_POLL  = 2'd0,
    MODE_MAP   = 2'd1,
    MODE_RESET = 2'd2
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STATES = 3'd0,
    CFG_READ_CYCLE = 3'd1,
    CFG_DEBOUNCE   = 3'd2,
    CFG_INVERT     = 3'd3,
    CFG_MAP_EN     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [NS_W-1:0] num_states;
    logic [MS_W-1:0] read_cycle_ms;
    logic [MS_W-1:0] debounce_ms;
    logic            invert_raw;
    logic            mapping_enable;
  } cfg_t;

  // tracked state after one item
  typedef struct packed {
    logic               changed;
    logic [STATE_W-1:0] current_state;
    logic               current_valid;
    logic [STATE_W-1:0] previous_state;
    logic               previous_valid;
  } res_t;

  // mapping table write request
  typedef struct packed {
    logic               en;
    logic [STATE_W-1:0] idx;
    logic [MAP_W-1:0]   val;
  } map_wr_t;

endpackage
`default_nettype wire

// ===== src/sdst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sdst_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/sdst_core.sv =====
// Debounce and state tracking: poll timing, level conditioning, state update.
`default_nettype none
module sdst_core #(
  parameter int MAX_STATES = sdst_pkg::MAX_STATES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  sdst_pkg::mode_t                mode,
  input  logic [sdst_pkg::TIME_W-1:0]    now_ms,
  input  logic [sdst_pkg::STATE_W-1:0]   raw_level,
  input  logic [sdst_pkg::STATE_W-1:0]   map_index,
  input  logic [sdst_pkg::MAP_W-1:0]     map_value,
  input  sdst_pkg::cfg_t                 cfg,
  output sdst_pkg::res_t                 res,
  output sdst_pkg::map_wr_t              map_wr
);

  logic [sdst_pkg::STATE_W-1:0] cur_r, cur_nxt, prev_r, prev_nxt, lraw_r, lraw_nxt;
  logic                         ck_r, ck_nxt, pk_r, pk_nxt, lrk_r, lrk_nxt;
  logic                         dba_r, dba_nxt;
  logic [sdst_pkg::TIME_W-1:0]  lrt_r, lrt_nxt;

  logic [sdst_pkg::NS_W-1:0]    ns, raw7, sat7, lvl7;
  logic [sdst_pkg::STATE_W-1:0] lvl;
  logic [sdst_pkg::TIME_W-1:0]  diff;
  logic [sdst_pkg::MS_W-1:0]    wait_ms;
  logic                         due, chg;

  // effective number of states, clamped
  always_comb begin
    if (cfg.num_states < sdst_pkg::NS_W'(sdst_pkg::NS_MIN)) begin
      ns = sdst_pkg::NS_W'(sdst_pkg::NS_MIN);
    end else if (cfg.num_states > sdst_pkg::NS_W'(MAX_STATES)) begin
      ns = sdst_pkg::NS_W'(MAX_STATES);
    end else begin
      ns = cfg.num_states;
    end
  end

  // level: saturate then optionally invert
  always_comb begin
    raw7 = {1'b0, raw_level};
    sat7 = (raw7 >= ns) ? ns - 1'b1 : raw7;
    lvl7 = cfg.invert_raw ? ns - 1'b1 - sat7 : sat7;
    lvl  = lvl7[sdst_pkg::STATE_W-1:0];
  end

  // poll is due once the relevant wait has passed (wrapping difference)
  assign diff    = now_ms - lrt_r;
  assign wait_ms = dba_r ? cfg.debounce_ms : cfg.read_cycle_ms;
  assign due     = diff >= sdst_pkg::TIME_W'(wait_ms);

  // next state for the item on the input
  always_comb begin
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    lraw_nxt = lraw_r;
    ck_nxt   = ck_r;
    pk_nxt   = pk_r;
    lrk_nxt  = lrk_r;
    dba_nxt  = dba_r;
    lrt_nxt  = lrt_r;
    chg      = 1'b0;
    map_wr.en  = 1'b0;
    map_wr.idx = map_index;
    map_wr.val = map_value;
    unique case (mode)
      sdst_pkg::MODE_POLL: begin
        if (due) begin
          lrt_nxt = now_ms;
          if (!dba_r && cfg.debounce_ms != '0 && (!lrk_r || lraw_r != lvl)) begin
            dba_nxt = 1'b1;
          end else begin
            dba_nxt  = 1'b0;
            lraw_nxt = lvl;
            lrk_nxt  = 1'b1;
            if (!ck_r || cur_r != lvl) begin
              prev_nxt = cur_r;
              pk_nxt   = ck_r;
              cur_nxt  = lvl;
              ck_nxt   = 1'b1;
              chg      = 1'b1;
            end
          end
        end
      end
      sdst_pkg::MODE_MAP: begin
        map_wr.en = cfg.mapping_enable && ({1'b0, map_index} < ns);
      end
      sdst_pkg::MODE_RESET: begin
        cur_nxt  = '0;
        prev_nxt = '0;
        lraw_nxt = '0;
        ck_nxt   = 1'b0;
        pk_nxt   = 1'b0;
        lrk_nxt  = 1'b0;
        dba_nxt  = 1'b0;
        lrt_nxt  = '0;
      end
      default: begin
      end
    endcase
    map_wr.en = map_wr.en && fire;
  end

  // result view of the updated state
  always_comb begin
    res.changed        = chg;
    res.current_state  = ck_nxt ? cur_nxt : '0;
    res.current_valid  = ck_nxt;
    res.previous_state = pk_nxt ? prev_nxt : '0;
    res.previous_valid = pk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      prev_r <= '0;
      lraw_r <= '0;
      ck_r   <= 1'b0;
      pk_r   <= 1'b0;
      lrk_r  <= 1'b0;
      dba_r  <= 1'b0;
      lrt_r  <= '0;
    end else if (fire) begin
      cur_r  <= cur_nxt;
      prev_r <= prev_nxt;
      lraw_r <= lraw_nxt;
      ck_r   <= ck_nxt;
      pk_r   <= pk_nxt;
      lrk_r  <= lrk_nxt;
      dba_r  <= dba_nxt;
      lrt_r  <= lrt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sdst_map.sv =====
// Mapping table: two RAM copies for two reads, valid bits, write forwarding.
`default_nettype none
module sdst_map #(
  parameter int MAX_STATES = sdst_pkg::MAX_STATES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  sdst_pkg::res_t                res,
  input  logic                          map_en,
  input  sdst_pkg::map_wr_t             map_wr,
  output logic [sdst_pkg::MAP_W-1:0]    mapped_current,
  output logic [sdst_pkg::MAP_W-1:0]    mapped_previous
);

  localparam int AW = $clog2(MAX_STATES);

  logic [MAX_STATES-1:0]          vld_r;
  logic [AW-1:0]                  wa, ca, pa;
  logic [sdst_pkg::MAP_W-1:0]     cq, pq;
  logic [sdst_pkg::STATE_W-1:0]   cs_r, ps_r;
  logic                           ck_r, pk_r, en_r;
  logic                           chit_r, phit_r, cvld_r, pvld_r;
  logic [sdst_pkg::MAP_W-1:0]     wval_r;

  assign wa = map_wr.idx[AW-1:0];
  assign ca = res.current_state[AW-1:0];
  assign pa = res.previous_state[AW-1:0];

  sdst_ram #(.W(sdst_pkg::MAP_W), .D(MAX_STATES)) u_ram_cur (
    .clk(clk), .we(map_wr.en), .waddr(wa), .wdata(map_wr.val),
    .re(rd_en), .raddr(ca), .rdata(cq)
  );

  sdst_ram #(.W(sdst_pkg::MAP_W), .D(MAX_STATES)) u_ram_prev (
    .clk(clk), .we(map_wr.en), .waddr(wa), .wdata(map_wr.val),
    .re(rd_en), .raddr(pa), .rdata(pq)
  );

  // entries never written read as their own index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (map_wr.en) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // side information aligned with the RAM read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cs_r   <= res.current_state;
      ps_r   <= res.previous_state;
      ck_r   <= res.current_valid;
      pk_r   <= res.previous_valid;
      en_r   <= map_en;
      chit_r <= map_wr.en && wa == ca;
      phit_r <= map_wr.en && wa == pa;
      cvld_r <= vld_r[ca];
      pvld_r <= vld_r[pa];
      wval_r <= map_wr.val;
    end
  end

  // select zero for no state, forwarded write, stored entry or identity
  always_comb begin
    if (!ck_r) begin
      mapped_current = '0;
    end else if (en_r && chit_r) begin
      mapped_current = wval_r;
    end else if (en_r && cvld_r) begin
      mapped_current = cq;
    end else begin
      mapped_current = sdst_pkg::MAP_W'(cs_r);
    end
    if (!pk_r) begin
      mapped_previous = '0;
    end else if (en_r && phit_r) begin
      mapped_previous = wval_r;
    end else if (en_r && pvld_r) begin
      mapped_previous = pq;
    end else begin
      mapped_previous = sdst_pkg::MAP_W'(ps_r);
    end
  end

endmodule
`default_nettype wire

// ===== src/switch_debounce_state_tracker.sv =====
// Top level: stream ports, configuration registers, pipeline and output register.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tuser mode, in_tdata timestamp, level, map
//  out_    | out | out_tvalid/out_tready| out_tdata flags, states, mapped states
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the state update and table read
// are registered in the middle stage, followed by the output register. The rate is set by
// the tracking registers, updated once per accepted item, and one read port per table copy.
// Table entries read as identity after reset via per-entry valid bits; no clear pass.
// in_tready and cfg_ready stay low while reset is asserted.
// A stalled output holds the middle stage, and the input stalls once that is full.
`default_nettype none
module switch_debounce_state_tracker #(
  parameter int MAX_STATES = sdst_pkg::MAX_STATES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [55:0]                       in_tdata,  // now_ms, raw_level, map_index, map_value
  input  logic [1:0]                        in_tuser,  // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // changed, current_state, current_valid, previous_state, previous_valid,
  // mapped_current, mapped_previous
  output logic [31:0]                       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sdst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdst_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sdst_pkg::cfg_t    cfg_r;
  sdst_pkg::res_t    res, s1_res_r;
  sdst_pkg::map_wr_t map_wr;
  logic              in_fire, s1_valid_r, s1_valid_nxt, s1_move;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r;
  logic [sdst_pkg::MAP_W-1:0] mc, mp;

  // configuration registers
  assign cfg_ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_states     <= sdst_pkg::NS_W'(sdst_pkg::NS_MIN);
      cfg_r.read_cycle_ms  <= '0;
      cfg_r.debounce_ms    <= '0;
      cfg_r.invert_raw     <= 1'b0;
      cfg_r.mapping_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdst_pkg::CFG_NUM_STATES: cfg_r.num_states    <= cfg_data[sdst_pkg::NS_W-1:0];
        sdst_pkg::CFG_READ_CYCLE: cfg_r.read_cycle_ms <= cfg_data;
        sdst_pkg::CFG_DEBOUNCE:   cfg_r.debounce_ms   <= cfg_data;
        sdst_pkg::CFG_INVERT:     cfg_r.invert_raw    <= cfg_data[0];
        sdst_pkg::CFG_MAP_EN:     cfg_r.mapping_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // handshake and stage control
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || s1_move);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  sdst_core #(.MAX_STATES(MAX_STATES)) u_core (
    .clk(clk), .rst_n(rst_n), .fire(in_fire),
    .mode(sdst_pkg::mode_t'(in_tuser)),
    .now_ms(in_tdata[31:0]), .raw_level(in_tdata[37:32]),
    .map_index(in_tdata[43:38]), .map_value(in_tdata[51:44]),
    .cfg(cfg_r), .res(res), .map_wr(map_wr)
  );

  sdst_map #(.MAX_STATES(MAX_STATES)) u_map (
    .clk(clk), .rst_n(rst_n), .rd_en(in_fire), .res(res),
    .map_en(cfg_r.mapping_enable), .map_wr(map_wr),
    .mapped_current(mc), .mapped_previous(mp)
  );

  // middle stage, aligned with table read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      s1_res_r <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (s1_move) begin
      out_data_r <= {1'b0, mp, mc, s1_res_r.previous_valid, s1_res_r.previous_state,
                     s1_res_r.current_valid, s1_res_r.current_state, s1_res_r.changed};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a change always leaves a valid current state
  a_changed_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || out_tdata[7]))
    else $error("changed without valid current state");

  // undefined current state reports zero
  a_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[7]) |-> (out_tdata[6:1] == '0 && out_tdata[22:15] == '0))
    else $error("undefined current state not zero");

  // previous state only exists once a current one does
  a_prev_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[14]) |-> out_tdata[7])
    else $error("previous valid without current valid");

  // an empty middle stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty pipeline");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the switch debounce state tracker.
`default_nettype none
module tb_top;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 125;
  localparam int         LONG_HOLD   = 80;
  localparam int         DRAIN_WAIT  = 10;
  localparam int         CYCLE_LIMIT = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [55:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = sdst_pkg::MODE_POLL;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [sdst_pkg::CFG_IDX_W-1:0]  cfg_index = sdst_pkg::CFG_NUM_STATES;
  logic [sdst_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic        cfg_ready;

  switch_debounce_state_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // now_ms, raw_level, map_index, map_value
    .in_tuser   (in_tuser),   // mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // changed, current_state, current_valid, previous_state, previous_valid,
    // mapped_current, mapped_previous
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow copy of the registers and tracking state
  logic [sdst_pkg::NS_W-1:0]    sh_num_states = 7'd2;
  logic [sdst_pkg::MS_W-1:0]    sh_read_cycle = '0;
  logic [sdst_pkg::MS_W-1:0]    sh_debounce   = '0;
  logic                         sh_invert     = 1'b0;
  logic                         sh_map_en     = 1'b0;
  logic [sdst_pkg::STATE_W-1:0] trk_cur, trk_prev, trk_last_raw;
  logic                         trk_cur_ok, trk_prev_ok, trk_last_raw_ok, trk_bouncing;
  logic [sdst_pkg::TIME_W-1:0]  trk_last_read;
  logic [sdst_pkg::MAP_W-1:0]   trk_map [sdst_pkg::MAX_STATES_DEF];

  logic [31:0] pending_results [$];
  logic [32:0] typed_results [$];   // bit 32 set: use the typed word, not the prediction
  int          items_sent   = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          stall_long      = 1'b0;
  bit          stall_long_done = 1'b0;

  function automatic logic [sdst_pkg::NS_W-1:0] states_in_use();
    if (sh_num_states < 7'(sdst_pkg::NS_MIN)) return 7'(sdst_pkg::NS_MIN);
    if (sh_num_states > 7'(sdst_pkg::MAX_STATES_DEF)) return 7'(sdst_pkg::MAX_STATES_DEF);
    return sh_num_states;
  endfunction

  function automatic void clear_tracking();
    trk_cur = '0; trk_cur_ok = 1'b0;
    trk_prev = '0; trk_prev_ok = 1'b0;
    trk_last_raw = '0; trk_last_raw_ok = 1'b0;
    trk_last_read = '0;
    trk_bouncing = 1'b0;
  endfunction

  function automatic logic [sdst_pkg::MAP_W-1:0] map_of(logic [sdst_pkg::STATE_W-1:0] s,
                                                        logic ok);
    if (!ok) return '0;
    if (sh_map_en) return trk_map[s];
    return {2'b00, s};
  endfunction

  function automatic logic [31:0] pack_result(logic chg, logic [5:0] cur, logic cv,
                                              logic [5:0] prev, logic pv,
                                              logic [7:0] mc, logic [7:0] mp);
    return {1'b0, mp, mc, pv, prev, cv, cur, chg};
  endfunction

  function automatic logic [55:0] pack_item(logic [31:0] now, logic [5:0] raw,
                                            logic [5:0] idx, logic [7:0] val);
    return {4'b0000, val, idx, raw, now};
  endfunction

  // one poll: returns 1 when a new state is taken
  function automatic logic poll_level(logic [31:0] now, logic [5:0] raw_in);
    logic [31:0] elapsed;
    logic [6:0]  ns;
    logic [6:0]  lvl;
    elapsed = now - trk_last_read;
    ns = states_in_use();
    if (trk_bouncing) begin
      if (elapsed < {24'd0, sh_debounce}) return 1'b0;
    end else if (sh_read_cycle != 0 && elapsed < {24'd0, sh_read_cycle}) begin
      return 1'b0;
    end
    trk_last_read = now;
    lvl = {1'b0, raw_in};
    if (lvl >= ns) lvl = ns - 7'd1;
    if (sh_invert) lvl = ns - 7'd1 - lvl;
    // a new level starts the debounce wait; it is taken on the next due poll
    if (!trk_bouncing && sh_debounce != 0 &&
        (!trk_last_raw_ok || trk_last_raw != lvl[5:0])) begin
      trk_bouncing = 1'b1;
      return 1'b0;
    end
    trk_bouncing = 1'b0;
    trk_last_raw = lvl[5:0];
    trk_last_raw_ok = 1'b1;
    if (!trk_cur_ok || trk_cur != lvl[5:0]) begin
      trk_prev = trk_cur;
      trk_prev_ok = trk_cur_ok;
      trk_cur = lvl[5:0];
      trk_cur_ok = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] track_item(logic [1:0] mode, logic [55:0] data);
    logic chg;
    chg = 1'b0;
    case (mode)
      sdst_pkg::MODE_POLL:  chg = poll_level(data[31:0], data[37:32]);
      sdst_pkg::MODE_MAP: begin
        if (sh_map_en && {1'b0, data[43:38]} < states_in_use())
          trk_map[data[43:38]] = data[51:44];
      end
      sdst_pkg::MODE_RESET: clear_tracking();
      default: ;
    endcase
    return pack_result(chg, trk_cur_ok ? trk_cur : 6'd0, trk_cur_ok,
                       trk_prev_ok ? trk_prev : 6'd0, trk_prev_ok,
                       map_of(trk_cur, trk_cur_ok), map_of(trk_prev, trk_prev_ok));
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // watch all three channels: keep the shadow up to date and check results
  always @(posedge clk) begin : watch
    logic [32:0] typed;
    logic [31:0] predicted;
    logic [31:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdst_pkg::CFG_NUM_STATES: sh_num_states = cfg_data[6:0];
          sdst_pkg::CFG_READ_CYCLE: sh_read_cycle = cfg_data;
          sdst_pkg::CFG_DEBOUNCE:   sh_debounce   = cfg_data;
          sdst_pkg::CFG_INVERT:     sh_invert     = cfg_data[0];
          sdst_pkg::CFG_MAP_EN:     sh_map_en     = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        typed = typed_results.pop_front();
        predicted = track_item(in_tuser, in_tdata);
        pending_results.push_back(typed[32] ? typed[31:0] : predicted);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none got %0h", $time, out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("changed",         {7'd0, want[0]},     {7'd0, out_tdata[0]});
          check_field("current_state",   {2'd0, want[6:1]},   {2'd0, out_tdata[6:1]});
          check_field("current_valid",   {7'd0, want[7]},     {7'd0, out_tdata[7]});
          check_field("previous_state",  {2'd0, want[13:8]},  {2'd0, out_tdata[13:8]});
          check_field("previous_valid",  {7'd0, want[14]},    {7'd0, out_tdata[14]});
          check_field("mapped_current",  want[22:15],         out_tdata[22:15]);
          check_field("mapped_previous", want[30:23],         out_tdata[30:23]);
          check_field("pad",             {7'd0, want[31]},    {7'd0, out_tdata[31]});
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stretches of differing readiness, plus one long hold-off
  initial begin : drain
    int   stretch;
    int   style;
    logic rdy;
    @(posedge clk);
    forever begin
      stretch = $urandom_range(1, 40);
      style   = $urandom_range(0, 3);
      repeat (stretch) begin
        case (style)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom);
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ~out_tready;
        endcase
        out_tready <= rdy;
        @(posedge clk);
      end
      if (stall_long && !stall_long_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_long_done = 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [55:0] data,
                           input logic [32:0] typed);
    typed_results.push_back(typed);
    in_tuser  <= mode;
    in_tdata  <= data;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input sdst_pkg::cfg_idx_t idx, input logic [7:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (results_seen != items_sent) @(posedge clk);
  endtask

  typedef struct packed {
    logic                 is_cfg;
    sdst_pkg::cfg_idx_t   reg_idx;
    logic [7:0]           reg_val;
    logic [1:0]           mode;
    logic [31:0]          now;
    logic [5:0]           raw;
    logic [5:0]           idx;
    logic [7:0]           val;
    logic                 typed;
    logic [31:0]          result;
  } step_t;

  initial begin : stimulus
    step_t       steps [$];
    step_t       s;
    logic [31:0] t_now;
    logic [31:0] dt;
    logic [5:0]  lvl;
    logic [5:0]  idx;
    logic [7:0]  ns_w, rc_w, db_w;
    logic        inv_w, map_w;
    int          ns_eff, span, hold_left, left, burst, gap, r;

    clear_tracking();
    for (int i = 0; i < sdst_pkg::MAX_STATES_DEF; i++) trk_map[i] = 8'(i);

    // directed rows: cfg?, reg, value, mode, now, raw, idx, val, typed?, result
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_RESET, 0, 0, 0, 0,
                      1, pack_result(0, 0, 0, 0, 0, 0, 0)});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, MODE_SPARE, 0, 0, 0, 0,
                      1, pack_result(0, 0, 0, 0, 0, 0, 0)});
    // first read always counts as a change
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL, 0, 0, 0, 0,
                      1, pack_result(1, 0, 1, 0, 0, 0, 0)});
    // level above the state count saturates
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL, 1, 63, 0, 0,
                      1, pack_result(1, 1, 1, 0, 1, 1, 0)});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL, 2, 1, 0, 0,
                      0, 0});
    // table write ignored while mapping is off
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_MAP, 0, 0, 1, 8'hAB,
                      1, pack_result(0, 1, 1, 0, 1, 1, 0)});
    steps.push_back('{1, sdst_pkg::CFG_MAP_EN, 1, sdst_pkg::MODE_POLL, 0, 0, 0, 0, 0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_MAP, 0, 0, 1, 8'hFF,
                      1, pack_result(0, 1, 1, 0, 1, 8'hFF, 0)});
    // index beyond the state count is ignored
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_MAP, 0, 0, 2, 8'h55,
                      0, 0});
    // state count below range acts as two, then inversion
    steps.push_back('{1, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL, 0, 0, 0, 0,
                      0, 0});
    steps.push_back('{1, sdst_pkg::CFG_INVERT, 1, sdst_pkg::MODE_POLL, 0, 0, 0, 0, 0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL, 3, 40, 0, 0,
                      0, 0});
    // state count above range acts as sixty-four
    steps.push_back('{1, sdst_pkg::CFG_NUM_STATES, 127, sdst_pkg::MODE_POLL, 0, 0, 0, 0,
                      0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL,
                      32'hFFFF_FFFF, 0, 0, 0, 0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_MAP, 0, 0, 63, 8'h00,
                      0, 0});
    // read interval across the timestamp wrap
    steps.push_back('{1, sdst_pkg::CFG_READ_CYCLE, 255, sdst_pkg::MODE_POLL, 0, 0, 0, 0,
                      0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL,
                      32'h0000_00FE, 63, 0, 0, 0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL,
                      32'h0000_0100, 9, 0, 0, 0, 0});
    // debounce: start, too early, then due
    steps.push_back('{1, sdst_pkg::CFG_DEBOUNCE, 255, sdst_pkg::MODE_POLL, 0, 0, 0, 0,
                      0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL,
                      32'h0000_0200, 10, 0, 0, 0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL,
                      32'h0000_02FE, 10, 0, 0, 0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL,
                      32'h0000_02FF, 10, 0, 0, 0, 0});
    // soft reset keeps the table
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_RESET, 0, 0, 0, 0,
                      1, pack_result(0, 0, 0, 0, 0, 0, 0)});
    steps.push_back('{1, sdst_pkg::CFG_DEBOUNCE, 0, sdst_pkg::MODE_POLL, 0, 0, 0, 0, 0, 0});
    steps.push_back('{1, sdst_pkg::CFG_READ_CYCLE, 0, sdst_pkg::MODE_POLL, 0, 0, 0, 0,
                      0, 0});
    steps.push_back('{0, sdst_pkg::CFG_NUM_STATES, 0, sdst_pkg::MODE_POLL, 5, 0, 0, 0,
                      0, 0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      s = steps[i];
      if (s.is_cfg) begin
        in_tvalid <= 1'b0;
        wait_idle();
        write_reg(s.reg_idx, s.reg_val);
      end else begin
        send_item(s.mode, pack_item(s.now, s.raw, s.idx, s.val), {s.typed, s.result});
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      in_tvalid <= 1'b0;
      wait_idle();
      case (phase)
        0: begin ns_w = 2;   rc_w = 0;   db_w = 0;   inv_w = 0; map_w = 0; end
        1: begin ns_w = 64;  rc_w = 255; db_w = 255; inv_w = 1; map_w = 1; end
        2: begin ns_w = 127; rc_w = 0;   db_w = 3;   inv_w = 0; map_w = 1; end
        3: begin ns_w = 1;   rc_w = 5;   db_w = 0;   inv_w = 1; map_w = 1; end
        default: begin
          ns_w  = 8'($urandom_range(0, 127));
          r     = $urandom_range(0, 3);
          rc_w  = (r == 0) ? 8'd0 : (r == 3) ? 8'd255 : 8'($urandom_range(1, 40));
          r     = $urandom_range(0, 3);
          db_w  = (r == 0) ? 8'd0 : (r == 3) ? 8'd255 : 8'($urandom_range(1, 40));
          inv_w = 1'($urandom);
          map_w = 1'($urandom);
        end
      endcase
      write_reg(sdst_pkg::CFG_NUM_STATES, ns_w);
      write_reg(sdst_pkg::CFG_READ_CYCLE, rc_w);
      write_reg(sdst_pkg::CFG_DEBOUNCE, db_w);
      write_reg(sdst_pkg::CFG_INVERT, {7'd0, inv_w});
      write_reg(sdst_pkg::CFG_MAP_EN, {7'd0, map_w});

      ns_eff = (ns_w < 2) ? 2 : (ns_w > 64) ? 64 : int'(ns_w);
      span   = (rc_w > db_w) ? int'(rc_w) : int'(db_w);
      t_now  = phase[0] ? 32'hFFFF_FF00 + 32'($urandom_range(0, 255)) : $urandom;
      lvl    = 6'($urandom_range(0, ns_eff - 1));
      hold_left = 0;
      left   = PHASE_ITEMS;
      if (phase == 3) stall_long = 1'b1;

      while (left > 0) begin
        burst = (phase == 3 && left == PHASE_ITEMS) ? 40 : $urandom_range(1, 30);
        if (burst > left) burst = left;
        repeat (burst) begin
          r = $urandom_range(0, 99);
          if (r < 82) begin
            // mostly steady levels so that debounce and read intervals get through
            if (hold_left == 0) begin
              lvl = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, ns_eff - 1))
                                                 : 6'($urandom);
              hold_left = $urandom_range(1, 5);
            end
            hold_left--;
            r = $urandom_range(0, 99);
            if (r < 60)      dt = 32'($urandom_range(0, span + 2));
            else if (r < 85) dt = (span > 0) ? 32'(span - $urandom_range(0, 1)) : 32'd0;
            else if (r < 95) dt = 32'($urandom_range(0, 3));
            else             dt = $urandom;
            t_now += dt;
            send_item(sdst_pkg::MODE_POLL,
                      pack_item(t_now, lvl, 6'($urandom), 8'($urandom)), '0);
          end else if (r < 92) begin
            idx = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, ns_eff - 1))
                                             : 6'($urandom);
            send_item(sdst_pkg::MODE_MAP,
                      pack_item($urandom, 6'($urandom), idx, 8'($urandom)), '0);
          end else begin
            send_item((r < 97) ? sdst_pkg::MODE_RESET : MODE_SPARE,
                      pack_item($urandom, 6'($urandom), 6'($urandom), 8'($urandom)), '0);
          end
          left--;
        end
        // gap after the burst; sometimes none at all
        if ($urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, 8);
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    in_tvalid <= 1'b0;
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
